// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character lookup for the base64 stream encoder.
package b64e_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [6:0] PAD_CHAR = 7'h3D;
   localparam logic [5:0] SYM_MASK = 6'h3F;

   localparam int SLOTS = 4;

   // one output character: a six-bit alphabet index or a pad
   typedef struct packed {
      logic       pad;
      logic [5:0] idx;
   } slot_type;

   // everything one input byte produces
   typedef struct packed {
      slot_type [SLOTS-1:0] slot;
      logic [1:0]           last;
      logic                 fin;
   } job_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } q_head_type;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [6:0] ch;
      logic [6:0] v;
      v = {1'b0, idx};
      if (idx < 6'd26) begin
         ch = 7'h41 + v;
      end else if (idx < 6'd52) begin
         ch = 7'h61 + v - 7'd26;
      end else if (idx < 6'd62) begin
         ch = 7'h30 + v - 7'd52;
      end else if (idx == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

// ===== hw/rtl/b64e_req_if.sv =====
// Input channel: one raw byte per word, with the end-of-stream flag.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/b64e_rsp_if.sv =====
// Result channel: one ASCII character per word, with item and stream end marks.
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       item_done;
   logic       stream_done;

   modport source (output valid, output out_char, output item_done, output stream_done,
                   input ready);
   modport sink   (input valid, input out_char, input item_done, input stream_done,
                   output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// Front end: tracks group phase and leftover bits, turns each byte into a job.
module b64e_front
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_chan,
   input  logic        q_full,
   output logic        push,
   output job_type     push_job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   logic [1:0] step_phase;
   logic [3:0] step_left;
   job_type    job;

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;
   assign push_job       = job;

   always_comb begin
      logic [7:0] b;
      b          = req_chan.data_byte;
      job        = '0;
      step_phase = 2'd0;
      step_left  = 4'd0;
      case (phase_ff)
         2'd1: begin
            job.slot[0].idx = {left_ff[1:0], b[7:4]};
            job.last        = 2'd0;
            step_left       = b[3:0];
            step_phase      = 2'd2;
         end
         2'd2: begin
            job.slot[0].idx = {left_ff, b[7:6]};
            job.slot[1].idx = b[5:0] & SYM_MASK;
            job.last        = 2'd1;
            step_left       = 4'd0;
            step_phase      = 2'd0;
         end
         default: begin
            job.slot[0].idx = b[7:2];
            job.last        = 2'd0;
            step_left       = {2'b00, b[1:0]};
            step_phase      = 2'd1;
         end
      endcase

      job.fin = req_chan.final_byte;
      if (req_chan.final_byte) begin
         case (step_phase)
            2'd1: begin
               job.slot[1].idx = {step_left[1:0], 4'b0000};
               job.slot[2].pad = 1'b1;
               job.slot[3].pad = 1'b1;
               job.last        = 2'd3;
            end
            2'd2: begin
               job.slot[1].idx = {step_left, 2'b00};
               job.slot[2].pad = 1'b1;
               job.last        = 2'd2;
            end
            default: begin
               job.last = 2'd1;
            end
         endcase
      end

      phase_in = phase_ff;
      left_in  = left_ff;
      if (push) begin
         phase_in = req_chan.final_byte ? 2'd0 : step_phase;
         left_in  = req_chan.final_byte ? 4'd0 : step_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         left_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Short job queue between the front and back ends.
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    push_job,
   input  logic       pop,
   output logic       full,
   output q_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: walks the head job into the output register, one character per cycle while the output is not stalled.
module b64e_back
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  q_head_type  head,
   output logic        pop,
   b64e_rsp_if.source  rsp_chan
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       item_done_ff, item_done_in;
   logic       stream_done_ff, stream_done_in;
   logic [1:0] pos_ff, pos_in;

   logic       step;
   logic       at_last;
   slot_type   cur;

   assign step    = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign at_last = (pos_ff == head.job.last);
   assign pop     = step && at_last;
   assign cur     = head.job.slot[pos_ff];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      out_char_in    = out_char_ff;
      item_done_in   = item_done_ff;
      stream_done_in = stream_done_ff;
      pos_in         = pos_ff;
      if (step) begin
         rsp_valid_in   = 1'b1;
         out_char_in    = cur.pad ? PAD_CHAR : b64_char(cur.idx);
         item_done_in   = at_last;
         stream_done_in = at_last && head.job.fin;
         pos_in         = at_last ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff    <= out_char_in;
      item_done_ff   <= item_done_in;
      stream_done_ff <= stream_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.item_done   = item_done_ff;
   assign rsp_chan.stream_done = stream_done_ff;

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: front end, job queue, back end.
//
//   channel    dir  word                                  flow control
//   req_chan   in   data_byte[7:0], final_byte             valid/ready
//   rsp_chan   out  out_char[6:0], item_done, stream_done  valid/ready
//
// A byte is taken every cycle while the job queue has room; each byte yields
// 1 to 4 characters (two when it completes a group, up to four at stream end),
// sent one per cycle by the back end while the output is not stalled.
// A byte's first character passes the job queue, then the output register.
// Synchronous reset clears group phase, leftover bits, queue and output valid.
// Output stalls back up through the queue into req_chan.ready.
module base64_stream_encoder
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_chan,
   b64e_rsp_if.source  rsp_chan
);

   logic       q_full;
   logic       push;
   job_type    push_job;
   logic       pop;
   q_head_type head;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/tb_base64_stream_encoder.sv =====
// Self-checking testbench for base64_stream_encoder: byte streams in, predicted characters out.
module tb_base64_stream_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [6:0] out_char;
      logic       item_done;
      logic       stream_done;
   } char_word_type;

   logic clock = 1'b0;
   logic reset;

   b64e_req_if req_if ();
   b64e_rsp_if rsp_if ();

   base64_stream_encoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   // encoder state mirror
   logic [1:0] group_phase = 2'd0;
   logic [3:0] leftover    = 4'd0;

   char_word_type expected_chars[$];
   int mismatches     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;

   function automatic logic [6:0] alpha_char(input logic [5:0] idx);
      byte c;
      c = B64_ALPHABET[idx];
      return c[6:0];
   endfunction

   function automatic char_word_type plain_char(input logic [6:0] ch);
      char_word_type w;
      w.out_char    = ch;
      w.item_done   = 1'b0;
      w.stream_done = 1'b0;
      return w;
   endfunction

   task automatic encode_byte(input logic [7:0] b, input logic fin);
      char_word_type words[4];
      int n;
      n = 0;
      case (group_phase)
         2'd1: begin
            words[n] = plain_char(alpha_char({leftover[1:0], b[7:4]}));
            n = n + 1;
            leftover = b[3:0];
            group_phase = 2'd2;
         end
         2'd2: begin
            words[n] = plain_char(alpha_char({leftover, b[7:6]}));
            n = n + 1;
            words[n] = plain_char(alpha_char(b[5:0]));
            n = n + 1;
            leftover = 4'd0;
            group_phase = 2'd0;
         end
         default: begin
            words[n] = plain_char(alpha_char(b[7:2]));
            n = n + 1;
            leftover = {2'b00, b[1:0]};
            group_phase = 2'd1;
         end
      endcase
      if (fin) begin
         if (group_phase == 2'd1) begin
            words[n] = plain_char(alpha_char({leftover[1:0], 4'b0000}));
            n = n + 1;
            words[n] = plain_char(PAD_CHAR);
            n = n + 1;
            words[n] = plain_char(PAD_CHAR);
            n = n + 1;
         end else if (group_phase == 2'd2) begin
            words[n] = plain_char(alpha_char({leftover, 2'b00}));
            n = n + 1;
            words[n] = plain_char(PAD_CHAR);
            n = n + 1;
         end
         group_phase = 2'd0;
         leftover = 4'd0;
      end
      words[n-1].item_done = 1'b1;
      words[n-1].stream_done = fin;
      for (int i = 0; i < n; i++) expected_chars = {expected_chars, words[i]};
   endtask

   task automatic note_mismatch(input string what, input char_word_type want,
                                input char_word_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected char %h item %b stream %b, got char %h item %b stream %b",
                  $realtime, what, want.out_char, want.item_done, want.stream_done,
                  got.out_char, got.item_done, got.stream_done);
      end
   endtask

   always @(posedge clock) begin : check_proc
      char_word_type got;
      char_word_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) encode_byte(req_if.data_byte, req_if.final_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            got.out_char    = rsp_if.out_char;
            got.item_done   = rsp_if.item_done;
            got.stream_done = rsp_if.stream_done;
            if (expected_chars.size() == 0) begin
               note_mismatch("unexpected word", '0, got);
            end else begin
               want = expected_chars.pop_front();
               if (got.out_char !== want.out_char || got.item_done !== want.item_done ||
                   got.stream_done !== want.stream_done) begin
                  note_mismatch("mismatch", want, got);
               end
            end
         end
      end
   end

   // output side: random stalls plus counted hold-off
   initial begin : rsp_ready_proc
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.final_byte <= fin;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_stream(input int len);
      for (int i = 0; i < len; i++) send_byte(random_byte(), i == len - 1);
   endtask

   task automatic send_random_streams(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
         send_random_stream(len);
         sent += len;
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h14, 1'b0);
      send_byte(8'hFB, 1'b0);
      send_byte(8'h9C, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'hD9, 1'b0);
      send_byte(8'h7E, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      wait_drain();
   endtask

   task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      send_random_streams(n_items);
      wait_drain();
   endtask

   // output held off long enough to back up into the input
   task automatic test_output_hold();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 300;
      send_random_streams(24);
      wait_drain();
   endtask

   // sender waits for every pending character between streams
   task automatic test_drain_pause();
      send_idle_pct = 0;
      recv_stall_pct = 13;
      for (int i = 0; i < 4; i++) begin
         send_random_stream($urandom_range(7, 1));
         wait_drain();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'h00;
      req_if.final_byte <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(50, 0, 0);
      test_random(45, 50, 0);
      test_random(45, 0, 50);
      test_random(45, 13, 13);
      test_output_hold();
      test_drain_pause();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
